// File: hw/rtl/chacha_pkg.sv
package chacha_pkg;

  // algorithm size
  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned RoundCycles  = 2 * DoubleRounds;
  localparam int unsigned RndW         = $clog2(RoundCycles);

  // stream and configuration widths
  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned AddrW  = 3;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [7:0][63:0]  ks_t;

  // "expand 32-byte k"
  localparam word_t Sigma [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  // configuration register indexes
  typedef enum logic [AddrW-1:0] {
    REG_KEY_0_7    = 3'd0,
    REG_KEY_8_15   = 3'd1,
    REG_KEY_16_23  = 3'd2,
    REG_KEY_24_31  = 3'd3,
    REG_NONCE_0_7  = 3'd4,
    REG_NONCE_8_11 = 3'd5,
    REG_START_CTR  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] key_0_7;
    logic [63:0] key_8_15;
    logic [63:0] key_16_23;
    logic [63:0] key_24_31;
    logic [63:0] nonce_0_7;
    logic [31:0] nonce_8_11;
    logic [31:0] start_ctr;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic round;
    logic diag;
    logic feed;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_block;
    logic out_free;
  } stat_t;

  typedef struct packed {
    word_t d;
    word_t c;
    word_t b;
    word_t a;
  } qr_t;

  // one quarter round
  function automatic qr_t quarter(word_t a_in, word_t b_in, word_t c_in, word_t d_in);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    qr_t   r;
    a = a_in;
    b = b_in;
    c = c_in;
    d = d_in;
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    return r;
  endfunction

  // four independent quarter rounds, column or diagonal pattern
  function automatic state_t chacha_round(state_t x, logic diag);
    state_t y;
    qr_t    q;
    int     s;
    int     b;
    int     c;
    int     d;
    y = x;
    s = diag ? 1 : 0;
    for (int i = 0; i < 4; i++) begin
      b = 4 + ((i + s) & 3);
      c = 8 + ((i + 2 * s) & 3);
      d = 12 + ((i + 3 * s) & 3);
      q = quarter(x[i], x[b], x[c], x[d]);
      y[i] = q.a;
      y[b] = q.b;
      y[c] = q.c;
      y[d] = q.d;
    end
    return y;
  endfunction

  // initial block state from key, counter and nonce
  function automatic state_t build_init(cfg_t cfg, word_t ctr);
    state_t x;
    x[0]  = Sigma[0];
    x[1]  = Sigma[1];
    x[2]  = Sigma[2];
    x[3]  = Sigma[3];
    x[4]  = cfg.key_0_7[31:0];
    x[5]  = cfg.key_0_7[63:32];
    x[6]  = cfg.key_8_15[31:0];
    x[7]  = cfg.key_8_15[63:32];
    x[8]  = cfg.key_16_23[31:0];
    x[9]  = cfg.key_16_23[63:32];
    x[10] = cfg.key_24_31[31:0];
    x[11] = cfg.key_24_31[63:32];
    x[12] = ctr;
    x[13] = cfg.nonce_0_7[31:0];
    x[14] = cfg.nonce_0_7[63:32];
    x[15] = cfg.nonce_8_11;
    return x;
  endfunction

  // byte mask for the valid bytes of a word
  function automatic logic [WordW-1:0] byte_mask(logic [CountW-1:0] cnt);
    logic [WordW-1:0] m;
    for (int k = 0; k < 8; k++) begin
      m[8*k +: 8] = (cnt > CountW'(k)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/chacha_ctrl.sv
module chacha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  chacha_pkg::stat_t   stat_i,
  output chacha_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FEED  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [chacha_pkg::RndW-1:0]   rnd_q, rnd_d;
  logic                          accept;
  logic                          rnd_last;

  // take a word only when idle and the output register is free
  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign rnd_last   = (rnd_q == chacha_pkg::RndW'(chacha_pkg::RoundCycles - 1));

  // next state and round count
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    unique case (state_q)
      ST_IDLE: begin
        rnd_d = '0;
        if (accept) begin
          state_d = stat_i.need_block ? ST_ROUND : ST_EMIT;
        end
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_last) begin
          state_d = ST_FEED;
        end
      end
      ST_FEED: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // commands; even rounds are column rounds, odd rounds diagonal
  always_comb begin
    cmd_o.accept = accept;
    cmd_o.round  = (state_q == ST_ROUND);
    cmd_o.diag   = rnd_q[0];
    cmd_o.feed   = (state_q == ST_FEED);
    cmd_o.emit   = (state_q == ST_EMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

// File: hw/rtl/chacha_dp.sv
module chacha_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  chacha_pkg::cfg_t                    cfg_i,
  input  chacha_pkg::cmd_t                    cmd_i,
  output chacha_pkg::stat_t                   stat_o,
  input  logic [chacha_pkg::WordW-1:0]        in_word_i,
  input  logic [chacha_pkg::CountW-1:0]       in_count_i,
  input  logic                                in_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [chacha_pkg::WordW-1:0]        out_word_o,
  output logic [chacha_pkg::CountW-1:0]       out_count_o,
  output logic                                out_last_o
);

  // message control state
  logic                  in_msg_q;
  logic [2:0]            pos_q;
  chacha_pkg::word_t     ctr_q;
  logic                  out_valid_q;

  // payload registers
  chacha_pkg::state_t                 x_q;
  chacha_pkg::ks_t                    ks_q;
  logic [chacha_pkg::WordW-1:0]       msg_q;
  logic [chacha_pkg::CountW-1:0]      cnt_q;
  logic                               last_q;
  logic [chacha_pkg::WordW-1:0]       out_word_q;
  logic [chacha_pkg::CountW-1:0]      out_count_q;
  logic                               out_last_q;

  chacha_pkg::word_t     ctr_eff;
  chacha_pkg::word_t     init_ctr;
  chacha_pkg::state_t    init_state;
  chacha_pkg::state_t    round_state;
  chacha_pkg::ks_t       feed_ks;

  // a new message reloads the block counter
  assign ctr_eff  = in_msg_q ? ctr_q : cfg_i.start_ctr;
  assign init_ctr = cmd_i.accept ? ctr_eff : ctr_q;

  assign init_state  = chacha_pkg::build_init(cfg_i, init_ctr);
  assign round_state = chacha_pkg::chacha_round(x_q, cmd_i.diag);

  // feed-forward, two state words per keystream word
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      feed_ks[j] = {x_q[2*j+1] + init_state[2*j+1], x_q[2*j] + init_state[2*j]};
    end
  end

  assign stat_o.need_block = (pos_q == 3'd0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q    <= 1'b0;
      pos_q       <= 3'd0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        in_msg_q <= 1'b1;
        ctr_q    <= ctr_eff;
      end
      if (cmd_i.feed) begin
        ctr_q <= ctr_q + 32'd1;
      end
      if (cmd_i.emit) begin
        if (last_q) begin
          in_msg_q <= 1'b0;
          pos_q    <= 3'd0;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // block state, keystream and word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      msg_q  <= in_word_i;
      cnt_q  <= in_count_i;
      last_q <= in_last_i;
      if (pos_q == 3'd0) begin
        x_q <= init_state;
      end
    end
    if (cmd_i.round) begin
      x_q <= round_state;
    end
    if (cmd_i.feed) begin
      ks_q <= feed_ks;
    end
    if (cmd_i.emit) begin
      out_word_q  <= (msg_q ^ ks_q[pos_q]) & chacha_pkg::byte_mask(cnt_q);
      out_count_q <= cnt_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;

endmodule

// File: hw/rtl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher: each accepted 64-bit message word (little-endian bytes) is XORed
// with the next eight keystream bytes; key, nonce and start counter come from the
// configuration channel, which may be written only while no word is in flight. A word
// that opens a keystream block (the first word of a message and every eighth word after)
// passes through the single round unit, which does one column or diagonal round of four
// quarter rounds per cycle, then a feed-forward step and an output step; any other word
// goes through the output step alone. One word is processed at a time. Bytes at and above
// the byte count are zero in the result, and tlast ends the message so the next word
// reloads the block counter from start_counter.
module chacha20_stream_cipher (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [chacha_pkg::AddrW-1:0]        cfg_addr_i,
  input  logic [63:0]                         cfg_wdata_i,
  // message input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [chacha_pkg::WordW-1:0]        s_axis_tdata,  // msg_word[63:0]
  input  logic [chacha_pkg::CountW-1:0]       s_axis_tuser,  // byte_count[3:0]
  input  logic                                s_axis_tlast,
  // cipher output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [chacha_pkg::WordW-1:0]        m_axis_tdata,  // cipher_word[63:0]
  output logic [chacha_pkg::CountW-1:0]       m_axis_tuser,  // out_byte_count[3:0]
  output logic                                m_axis_tlast
);

  chacha_pkg::cfg_t   cfg_q;
  chacha_pkg::cmd_t   cmd;
  chacha_pkg::stat_t  stat;

  // configuration register file
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (chacha_pkg::cfg_reg_e'(cfg_addr_i))
        chacha_pkg::REG_KEY_0_7:    cfg_q.key_0_7    <= cfg_wdata_i;
        chacha_pkg::REG_KEY_8_15:   cfg_q.key_8_15   <= cfg_wdata_i;
        chacha_pkg::REG_KEY_16_23:  cfg_q.key_16_23  <= cfg_wdata_i;
        chacha_pkg::REG_KEY_24_31:  cfg_q.key_24_31  <= cfg_wdata_i;
        chacha_pkg::REG_NONCE_0_7:  cfg_q.nonce_0_7  <= cfg_wdata_i;
        chacha_pkg::REG_NONCE_8_11: cfg_q.nonce_8_11 <= cfg_wdata_i[31:0];
        chacha_pkg::REG_START_CTR:  cfg_q.start_ctr  <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  chacha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  chacha_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (s_axis_tdata),
    .in_count_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata),
    .out_count_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // one word at a time: no new transaction right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // the output register was free at acceptance and the result is not ready yet
  a_out_free_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("output valid too early after acceptance");

  // bytes beyond the byte count are zero
  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser < 4'd8) |->
      ((m_axis_tdata >> {m_axis_tuser, 3'b000}) == 64'd0))
    else $error("invalid bytes not cleared");
`endif

endmodule
